// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== hdl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// types, codes and defaults for the bounded deque with search
// ----------------------------------------------------------------------------
package bdq_pkg;

    // default sizing
    localparam int BDQ_DEPTH  = 16;
    localparam int BDQ_WORD_W = 32;

    // field widths of the words on both channels
    localparam int CMD_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 4;
    localparam int OCC_W    = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEARCH    = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS  = 3'd4;

    // command word
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] data_word;
    } t_bdq_in;

    // result word
    typedef struct packed {
        logic [DATA_W-1:0]   result_word;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [OCC_W-1:0]    occupancy;
    } t_bdq_out;

endpackage

// ===== hdl/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// bounded double-ended queue of words with a front-to-back search
// ----------------------------------------------------------------------------
// usage
//   command channel (i_in_valid / o_in_stall / i_in_data): one command word
//   per transfer: insert front or back, remove front or back, or search.
//   result channel (o_out_valid / i_out_stall / o_out_data): exactly one
//   result word per command, in command order.
//   the entries sit in a single-port circular buffer of DEPTH words; one
//   slot adder and one equality comparator are reused under a small
//   sequencer, so the block works on one command at a time.
//   a search reads the entries from the front and stops at the first hit;
//   the scan rate of one entry per cycle is set by the buffer's one read
//   port. one-step commands pass through the execute and finish states
//   before their result is loaded into the output register.
//   a finished result waits in an output register; the next command is
//   accepted meanwhile, and only its own result waits for that register.
//   reset (synchronous, active low) empties the queue and drops any result.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
    parameter int DEPTH  = bdq_pkg::BDQ_DEPTH,
    parameter int WORD_W = bdq_pkg::BDQ_WORD_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bdq_pkg::t_bdq_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output bdq_pkg::t_bdq_out o_out_data
);
    import bdq_pkg::*;

    `include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_CMP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [CMD_W-1:0]    r_cmd, n_cmd;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [CW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_front, n_front;
    logic [CW-1:0]       r_count, n_count;
    logic [WORD_W-1:0]   r_res_word, n_res_word;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [CW-1:0]       r_pos, n_pos;
    logic                r_out_valid, n_out_valid;
    t_bdq_out            r_out, n_out;

    logic [WORD_W-1:0]   r_mem [DEPTH];
    logic [WORD_W-1:0]   r_rd_data;

    logic                w_in_accept;
    logic                w_load;
    logic                w_we;
    logic                w_upd;
    logic [63:0]         w_in64;
    logic [CW:0]         w_sum;
    logic [CW:0]         w_wrap;
    logic [AW-1:0]       w_slot;
    logic [CW-1:0]       w_cmp_idx;
    logic [63:0]         w_res64;
    logic [15:0]         w_pos16;
    logic [15:0]         w_occ16;

    assign w_in_accept = i_in_valid && (r_state == S_IDLE);
    assign w_load      = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign w_in64      = 64'(i_in_data.data_word);
    assign w_cmp_idx   = r_idx - CW'(1);

    // states that may move the entry count
    assign w_upd = (r_state == S_EXEC) || (r_state == S_CMP);

    // shared slot adder: front plus offset, wrapped once at DEPTH
    assign w_sum  = (CW + 1)'(r_front) + (CW + 1)'(r_idx);
    assign w_wrap = (w_sum >= (CW + 1)'(DEPTH)) ? (w_sum - (CW + 1)'(DEPTH)) : w_sum;
    assign w_slot = w_wrap[AW-1:0];

    // result fields sized to the channel
    assign w_res64 = 64'(r_res_word);
    assign w_pos16 = 16'(r_pos);
    assign w_occ16 = 16'(r_count);

    // entry buffer, one port shared by write and registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_slot] <= r_word;
        end
        r_rd_data <= r_mem[w_slot];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_word      = r_word;
        n_idx       = r_idx;
        n_front     = r_front;
        n_count     = r_count;
        n_res_word  = r_res_word;
        n_status    = r_status;
        n_pos       = r_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_cmd      = i_in_data.cmd;
                    n_word     = w_in64[WORD_W-1:0];
                    n_res_word = '0;
                    n_status   = ST_OK;
                    n_pos      = '0;
                    n_state    = S_EXEC;
                    case (i_in_data.cmd)
                        CMD_INS_FRONT: n_idx = CW'(DEPTH - 1);
                        CMD_INS_BACK:  n_idx = r_count;
                        CMD_REM_BACK:  n_idx = (r_count == '0) ? '0 : (r_count - CW'(1));
                        default:       n_idx = '0;
                    endcase
                end
            end

            S_EXEC: begin
                n_state = S_FIN;
                unique case (r_cmd) inside
                    CMD_INS_FRONT, CMD_INS_BACK: begin
                        if (r_word == '0) begin
                            n_status = ST_NULL;
                        end else if (r_count >= CW'(DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + CW'(1);
                            if (r_cmd == CMD_INS_FRONT) begin
                                n_front = w_slot;
                            end
                        end
                    end
                    CMD_REM_FRONT, CMD_REM_BACK: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_idx   = r_idx + CW'(1);
                            n_state = S_CMP;
                        end
                    end
                    CMD_SEARCH: begin
                        if (r_word == '0) begin
                            n_status = ST_NULL;
                        end else if (r_count == '0) begin
                            n_status = ST_MISS;
                        end else begin
                            n_idx   = r_idx + CW'(1);
                            n_state = S_CMP;
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end

            S_CMP: begin
                case (r_cmd)
                    CMD_REM_FRONT: begin
                        // r_idx is one here, so the adder gives the new front
                        n_res_word = r_rd_data;
                        n_front    = w_slot;
                        n_count    = r_count - CW'(1);
                        n_state    = S_FIN;
                    end
                    CMD_REM_BACK: begin
                        n_res_word = r_rd_data;
                        n_count    = r_count - CW'(1);
                        n_state    = S_FIN;
                    end
                    default: begin
                        // search: compare one entry per cycle, next read in flight
                        if (r_rd_data == r_word) begin
                            n_res_word = r_word;
                            n_pos      = w_cmp_idx;
                            n_status   = ST_OK;
                            n_state    = S_FIN;
                        end else if (r_idx == r_count) begin
                            n_status = ST_MISS;
                            n_state  = S_FIN;
                        end else begin
                            n_idx = r_idx + CW'(1);
                        end
                    end
                endcase
            end

            S_FIN: begin
                if (w_load) begin
                    n_out.result_word = w_res64[DATA_W-1:0];
                    n_out.status      = r_status;
                    n_out.position    = w_pos16[POS_W-1:0];
                    n_out.occupancy   = w_occ16[OCC_W-1:0];
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_word     <= n_word;
        r_idx      <= n_idx;
        r_res_word <= n_res_word;
        r_status   <= n_status;
        r_pos      <= n_pos;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `ASSERT_CLK(a_count_bound, r_count <= CW'(DEPTH), "entry count above depth")
    `ASSERT_CLK(a_accept_exec, w_in_accept |=> r_state == S_EXEC, "accepted word not executed")
    `ASSERT_CLK(a_load_done, w_load |=> o_out_valid && r_state == S_IDLE, "result load lost")
    `ASSERT_CLK(a_count_moves, $past(i_rst_n) && !$stable(r_count) |-> $past(w_upd), "count moved")
    `ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid && !o_in_stall, "not idle after reset")

endmodule
